// File: rtl/core/m4ci_pkg.sv
// Shared types, constants and the cofactor term table of the 4x4 adjugate inverse core.
`default_nettype none
package m4ci_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS = 33;
  localparam int CW = 100;
  localparam int DW = 132;
  localparam int MW = 33;
  localparam int PW = 2 * MW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_TERM,
    ST_DET,
    ST_DET_END,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_CLR,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef struct packed {
    mac_op_t    op;
    logic [1:0] limb;
  } mac_ctrl_t;

  // Element index of factor j of term t of cofactor o.
  function automatic logic [3:0] cof_idx(input logic [3:0] o, input logic [2:0] t,
                                         input logic [1:0] j);
    logic [71:0] row;
    logic [4:0]  pos;
    logic [4:0]  sel;
    unique case (o)
      4'd0:  row = 72'h5AF5BE96F97ED6BD7A;
      4'd1:  row = 72'h1AF1BE92F93ED2BD3A;
      4'd2:  row = 72'h16F17E52F53ED27D36;
      4'd3:  row = 72'h16B17A52B53A927936;
      4'd4:  row = 72'h4AF4BE86F87EC6BC7A;
      4'd5:  row = 72'h0AF0BE82F83EC2BC3A;
      4'd6:  row = 72'h06F07E42F43EC27C36;
      4'd7:  row = 72'h06B07A42B43A827836;
      4'd8:  row = 72'h49F4BD85F87DC5BC79;
      4'd9:  row = 72'h09F0BD81F83DC1BC39;
      4'd10: row = 72'h05F07D41F43DC17C35;
      4'd11: row = 72'h05B07941B439817835;
      4'd12: row = 72'h49E4AD85E86DC5AC69;
      4'd13: row = 72'h09E0AD81E82DC1AC29;
      4'd14: row = 72'h05E06D41E42DC16C25;
      4'd15: row = 72'h05A06941A429816825;
      default: row = '0;
    endcase
    pos = 5'(t) * 5'd3 + 5'(j);
    sel = 5'd17 - pos;
    if (pos > 5'd17) begin
      return 4'd0;
    end
    return row[{sel, 2'b00} +: 4];
  endfunction

  // Term t of cofactor o is subtracted when this is true.
  function automatic logic term_neg(input logic [3:0] o, input logic [2:0] t);
    logic base;
    base = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    return base ^ o[2] ^ o[0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mat4_cofactor_inverse_core.sv
// Top level of the 4x4 matrix inverse core: loader, sequencer, stores and result register.
// The core takes sixteen signed fixed-point elements, one beat each, in storage order;
// a beat with in_first_element set restarts the matrix at element 0. After the
// sixteenth beat the core stops accepting and computes the exact adjugate: the 96
// triple products run one after another on the one shared 33x33 multiplier, and the
// determinant is then formed from the first row. Each of the sixteen results then runs
// through the restoring divider, one quotient bit per cycle, and waits in the output
// register until taken. The core takes no new matrix until the last result has been
// taken. A zero determinant skips the divider and returns zeros flagged singular;
// quotients outside the 32-bit range are clipped and flagged saturated.
`default_nettype none
module mat4_cofactor_inverse_core #(
  parameter int FRAC_BITS = m4ci_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic               in_first_element,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_inverse_value,
  output logic                    out_singular,
  output logic                    out_saturated,
  output logic                    out_last_element
);
  import m4ci_pkg::*;

  localparam int NW = CW + 2 * FRAC_BITS;

  state_t state_r, state_nxt;

  logic [4:0]  cnt_r;
  logic [3:0]  o_r;
  logic [2:0]  t_r;
  logic [2:0]  s_r;
  logic [1:0]  k_r;

  // Matrix element store, one registered read port.
  logic [31:0] mat_mem [16];
  logic [31:0] rd_r;
  logic [3:0]  rd_addr;

  logic [31:0] ra_r, rc_r, re_r;
  logic [63:0] pab_r;

  logic [CW-1:0] cof_r [16];
  logic [3:0]    cof_sel;
  logic [127:0]  cofx;
  logic [31:0]   cof_limb;

  logic [DW-1:0] det_abs_r;
  logic          det_neg_r, det_zero_r;

  logic signed [MW-1:0] mx, my;
  logic signed [PW-1:0] mprod;
  logic [DW-1:0]        macc;
  mac_ctrl_t            mctrl;

  logic               div_start, div_done, div_sat;
  logic [31:0]        div_quot;
  logic signed [NW-1:0] num;

  logic [31:0] res_val_r;
  logic        res_sing_r, res_sat_r;

  logic        in_fire, out_fire;
  logic [4:0]  load_idx;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state_r == ST_EMIT);
  assign out_fire  = out_valid && out_ready;

  // A marked beat, or a full count, always restarts at element 0.
  assign load_idx = (in_first_element || cnt_r > 5'd15) ? 5'd0 : cnt_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_fire && load_idx == 5'd15) state_nxt = ST_TERM;
      ST_TERM:      if (s_r == 3'd6 && o_r == 4'd15) state_nxt = ST_DET;
      ST_DET:       if (s_r == 3'd6 && k_r == 2'd3) state_nxt = ST_DET_END;
      ST_DET_END:   state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = det_zero_r ? ST_EMIT : ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:      if (out_fire) state_nxt = (o_r == 4'd15) ? ST_LOAD : ST_DIV_START;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // Cofactor read and its 32-bit limbs for the determinant pass.
  assign cof_sel  = (state_r == ST_DET) ? {k_r, 2'b00} : o_r;
  assign cofx     = {{(128-CW){cof_r[cof_sel][CW-1]}}, cof_r[cof_sel]};
  assign cof_limb = cofx[{s_r[1:0] - 2'd2, 5'b00000} +: 32];
  assign num      = NW'($signed(cof_r[o_r])) <<< (2 * FRAC_BITS);
  assign div_start = (state_r == ST_DIV_START) && !det_zero_r;

  // Sequencer outputs: store address, multiplier operands and accumulator command.
  always_comb begin
    rd_addr    = 4'd0;
    mx         = '0;
    my         = '0;
    mctrl.op   = MAC_HOLD;
    mctrl.limb = 2'd0;
    unique case (state_r)
      ST_TERM: begin
        if (s_r <= 3'd2) begin
          rd_addr = cof_idx(o_r, t_r, s_r[1:0]);
        end
        unique case (s_r)
          3'd0: if (t_r == 3'd0) mctrl.op = MAC_CLR;
          3'd2: begin
            mx = {ra_r[31], ra_r};
            my = {rd_r[31], rd_r};
          end
          3'd3: begin
            mx = {rd_r[31], rd_r};
            my = {1'b0, mprod[31:0]};
          end
          3'd4: begin
            mx = {rc_r[31], rc_r};
            my = {pab_r[63], pab_r[63:32]};
            mctrl.op = term_neg(o_r, t_r) ? MAC_SUB : MAC_ADD;
          end
          3'd5: begin
            mctrl.op   = term_neg(o_r, t_r) ? MAC_SUB : MAC_ADD;
            mctrl.limb = 2'd1;
          end
          default: ;
        endcase
      end
      ST_DET: begin
        rd_addr = {2'b00, k_r};
        if (s_r == 3'd0 && k_r == 2'd0) begin
          mctrl.op = MAC_CLR;
        end
        if (s_r >= 3'd2 && s_r <= 3'd5) begin
          mx = {re_r[31], re_r};
          my = (s_r == 3'd5) ? {cof_limb[31], cof_limb} : {1'b0, cof_limb};
        end
        if (s_r >= 3'd3) begin
          mctrl.op   = MAC_ADD;
          mctrl.limb = s_r[1:0] - 2'd3;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      o_r     <= '0;
      t_r     <= '0;
      s_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            cnt_r <= (load_idx == 5'd15) ? 5'd0 : load_idx + 5'd1;
          end
          o_r <= '0;
          t_r <= '0;
          s_r <= '0;
          k_r <= '0;
        end
        ST_TERM: begin
          if (s_r == 3'd6) begin
            s_r <= '0;
            t_r <= '0;
            o_r <= o_r + 4'd1;
          end else if (s_r == 3'd5 && t_r != 3'd5) begin
            s_r <= '0;
            t_r <= t_r + 3'd1;
          end else begin
            s_r <= s_r + 3'd1;
          end
        end
        ST_DET: begin
          if (s_r == 3'd6) begin
            s_r <= '0;
            k_r <= k_r + 2'd1;
          end else begin
            s_r <= s_r + 3'd1;
          end
        end
        ST_DET_END: o_r <= '0;
        ST_EMIT:    if (out_fire) o_r <= o_r + 4'd1;
        default: ;
      endcase
    end
  end

  // Stores and operand registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mat_mem[load_idx[3:0]] <= in_element_value;
    end
    rd_r <= mat_mem[rd_addr];
    if (state_r == ST_TERM && s_r == 3'd1) ra_r <= rd_r;
    if (state_r == ST_TERM && s_r == 3'd3) begin
      rc_r  <= rd_r;
      pab_r <= mprod[63:0];
    end
    if (state_r == ST_TERM && s_r == 3'd6) cof_r[o_r] <= macc[CW-1:0];
    if (state_r == ST_DET && s_r == 3'd1) re_r <= rd_r;
    if (state_r == ST_DET_END) begin
      det_zero_r <= (macc == '0);
      det_neg_r  <= macc[DW-1];
      det_abs_r  <= macc[DW-1] ? (DW'(0) - macc) : macc;
    end
    if (state_r == ST_DIV_START && det_zero_r) begin
      res_val_r  <= '0;
      res_sing_r <= 1'b1;
      res_sat_r  <= 1'b0;
    end else if (state_r == ST_DIV_WAIT && div_done) begin
      res_val_r  <= div_quot;
      res_sing_r <= 1'b0;
      res_sat_r  <= div_sat;
    end
  end

  m4ci_mac #(.AW(DW)) u_mac (
    .clk  (clk),
    .x    (mx),
    .y    (my),
    .ctrl (mctrl),
    .prod (mprod),
    .acc  (macc)
  );

  m4ci_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .dabs  (det_abs_r),
    .dneg  (det_neg_r),
    .done  (div_done),
    .quot  (div_quot),
    .sat   (div_sat)
  );

  assign out_inverse_value = res_val_r;
  assign out_singular      = res_sing_r;
  assign out_saturated     = res_sat_r;
  assign out_last_element  = (o_r == 4'd15);

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // A result beat never leaves while the next matrix is loading.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  // The sixteenth element always starts the cofactor pass.
  a_load_to_term: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && load_idx == 5'd15) |=> (state_r == ST_TERM && s_r == 3'd0 && o_r == 4'd0))
    else $error("matrix completion did not start the computation");

  // A singular matrix yields zero results without saturation.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inverse_value == 32'sd0 && !out_saturated))
    else $error("singular result not zero");

endmodule
`default_nettype wire

// File: rtl/core/m4ci_mac.sv
// Shared 33x33 signed multiplier with a limb-shifted wide accumulator.
`default_nettype none
module m4ci_mac #(
  parameter int AW = m4ci_pkg::DW
) (
  input  wire logic                          clk,
  input  wire logic signed [m4ci_pkg::MW-1:0] x,
  input  wire logic signed [m4ci_pkg::MW-1:0] y,
  input  wire m4ci_pkg::mac_ctrl_t           ctrl,
  output logic signed [m4ci_pkg::PW-1:0]     prod,
  output logic [AW-1:0]                      acc
);
  import m4ci_pkg::*;

  logic signed [PW-1:0] prod_r;
  logic [AW-1:0]        acc_r;
  logic [AW-1:0]        addend;

  always_comb begin
    addend = {{(AW-PW){prod_r[PW-1]}}, prod_r};
    addend = addend << {ctrl.limb, 5'b00000};
  end

  always_ff @(posedge clk) begin
    prod_r <= x * y;
    unique case (ctrl.op)
      MAC_HOLD: acc_r <= acc_r;
      MAC_CLR:  acc_r <= '0;
      MAC_ADD:  acc_r <= acc_r + addend;
      MAC_SUB:  acc_r <= acc_r - addend;
      default:  acc_r <= acc_r;
    endcase
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule
`default_nettype wire

// File: rtl/core/m4ci_div.sv
// Restoring divider, one quotient bit per cycle, with truncation and 32-bit saturation.
`default_nettype none
module m4ci_div #(
  parameter int NW = m4ci_pkg::CW + 2 * m4ci_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [NW-1:0]       num,
  input  wire logic [m4ci_pkg::DW-1:0]    dabs,
  input  wire logic                       dneg,
  output logic                            done,
  output logic [31:0]                     quot,
  output logic                            sat
);
  import m4ci_pkg::*;

  localparam int RW = ((NW > DW + QBITS) ? NW : DW + QBITS) + 1;
  localparam logic [5:0] CNT_FIRST = 6'(QBITS + 1);

  logic [RW-1:0]    n_r, ds_r;
  logic [QBITS-1:0] q_r;
  logic             neg_r, busy_r, done_r, sat_r;
  logic [5:0]       cnt_r;
  logic [31:0]      quot_r;
  logic             ge;
  logic [QBITS-1:0] qf;
  logic [NW-1:0]    nabs;
  logic             fsat;
  logic [31:0]      fval;

  assign ge   = n_r >= ds_r;
  assign qf   = {q_r[QBITS-2:0], ge};
  assign nabs = num[NW-1] ? (NW'(0) - num) : num;

  // Final quotient with saturation; the first-step overflow case forces saturation.
  always_comb begin
    if (cnt_r == CNT_FIRST) begin
      fsat = 1'b1;
      fval = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!neg_r) begin
      fsat = qf[32] | qf[31];
      fval = fsat ? 32'h7FFF_FFFF : qf[31:0];
    end else begin
      fsat = qf[32] | (qf[31] & (|qf[30:0]));
      fval = fsat ? 32'h8000_0000 : (32'd0 - qf[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_FIRST;
        n_r    <= RW'(nabs);
        ds_r   <= RW'(dabs) << QBITS;
        neg_r  <= num[NW-1] ^ dneg;
        q_r    <= '0;
      end else if (busy_r) begin
        if ((cnt_r == CNT_FIRST && ge) || cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= fval;
          sat_r  <= fsat;
        end else begin
          if (ge && cnt_r != CNT_FIRST) begin
            n_r <= n_r - ds_r;
          end
          if (cnt_r != CNT_FIRST) begin
            q_r <= qf;
          end
          ds_r  <= ds_r >> 1;
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign sat  = sat_r;

endmodule
`default_nettype wire

// File: sim/mat4_cofactor_inverse_core_tb.sv
// Self-checking testbench for the 4x4 fixed-point adjugate inverse core.
`timescale 1ns / 1ps
`default_nettype none
module mat4_cofactor_inverse_core_tb;

  localparam int FRAC = 16;
  localparam int DIRECTED_ROWS = 35;
  localparam int RANDOM_BEATS = 370;
  localparam int LONG_HOLD_CYCLES = 500;

  // How the results of the matrix that a row completes are predicted.
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_IDENTITY,
    EXP_SINGULAR
  } exp_kind_t;

  typedef struct {
    logic signed [31:0] value;
    logic               first;
    exp_kind_t          kind;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] value;
    logic               singular;
    logic               saturated;
    logic               last;
  } inv_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_element_value = '0;
  logic in_first_element = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_inverse_value;
  logic out_singular;
  logic out_saturated;
  logic out_last_element;

  // The predictor's own copy of the matrix store and the load index.
  logic signed [31:0] mat_copy [16];
  int unsigned        load_idx;

  inv_elem_t    pending_inv[$];
  stim_row_t    directed[DIRECTED_ROWS];
  logic signed [31:0] gen_mtx [16];
  int           errors = 0;
  int           beats_sent = 0;
  int           results_seen = 0;
  bit           sender_done = 1'b0;

  always #1 clk = ~clk;

  mat4_cofactor_inverse_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_first_element (in_first_element),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_inverse_value(out_inverse_value),
    .out_singular     (out_singular),
    .out_saturated    (out_saturated),
    .out_last_element (out_last_element)
  );

  // Wide sign-extended copy of one stored element.
  function automatic logic signed [191:0] wide_elem(input int idx);
    logic signed [191:0] w;
    w = mat_copy[idx];
    return w;
  endfunction

  // Signed 3x3 minor of the stored matrix with one row and one column struck out.
  function automatic logic signed [191:0] minor3(input int skip_r, input int skip_c);
    int rows[3];
    int cols[3];
    int nr;
    int nc;
    logic signed [191:0] a[3][3];
    nr = 0;
    nc = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != skip_r) begin
        rows[nr] = i;
        nr++;
      end
      if (i != skip_c) begin
        cols[nc] = i;
        nc++;
      end
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = wide_elem(rows[r] * 4 + cols[c]);
    return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
         - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
         + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
  endfunction

  // Exact inverse of the stored matrix: each adjugate entry scaled by 2^(2*FRAC) and
  // divided by the determinant, truncated toward zero and clipped to 32 bits.
  task automatic predict_inverse();
    logic signed [191:0] adj[16];
    logic signed [191:0] det;
    logic signed [191:0] quo;
    inv_elem_t e;
    for (int o = 0; o < 16; o++) begin
      // Entry (r,c) of the adjugate is the cofactor of element (c,r).
      adj[o] = minor3(o % 4, o / 4);
      if (((o / 4) + (o % 4)) % 2 == 1) adj[o] = -adj[o];
    end
    det = '0;
    for (int k = 0; k < 4; k++) det += wide_elem(k) * adj[4 * k];
    for (int o = 0; o < 16; o++) begin
      e.last = (o == 15);
      e.singular = 1'b0;
      e.saturated = 1'b0;
      if (det == 0) begin
        e.value = '0;
        e.singular = 1'b1;
      end else begin
        quo = (adj[o] <<< (2 * FRAC)) / det;
        if (quo > 192'sd2147483647) begin
          e.value = 32'h7FFF_FFFF;
          e.saturated = 1'b1;
        end else if (quo < -192'sd2147483648) begin
          e.value = 32'h8000_0000;
          e.saturated = 1'b1;
        end else begin
          e.value = quo[31:0];
        end
      end
      pending_inv.push_back(e);
    end
  endtask

  // Typed-in results for the directed identity and zero matrices.
  task automatic push_known(input exp_kind_t kind);
    inv_elem_t e;
    for (int o = 0; o < 16; o++) begin
      e.last = (o == 15);
      e.saturated = 1'b0;
      e.singular = (kind == EXP_SINGULAR);
      e.value = (kind == EXP_IDENTITY && o % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
      pending_inv.push_back(e);
    end
  endtask

  // Mirror one accepted beat into the predictor's store.
  task automatic load_beat(input stim_row_t row);
    if (row.first) load_idx = 0;
    mat_copy[load_idx] = row.value;
    load_idx++;
    if (load_idx == 16) begin
      load_idx = 0;
      if (row.kind == EXP_PREDICT) predict_inverse();
      else push_known(row.kind);
    end
  endtask

  // Offer one beat after a random gap and hold it until the core takes it.
  // A zero gap keeps valid high, so back-to-back beats never drop valid in one step.
  task automatic send_beat(input stim_row_t row, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= row.value;
    in_first_element <= row.first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_beat(row);
    beats_sent++;
  endtask

  // Build one random matrix of a given flavor into gen_mtx.
  task automatic build_matrix(input int flavor);
    int r;
    for (int i = 0; i < 16; i++) begin
      case (flavor)
        0, 1, 2: begin
          // Diagonally dominant: well conditioned, results stay in range.
          if (i % 5 == 0) begin
            gen_mtx[i] = $urandom_range(1, 8) << FRAC;
            if ($urandom_range(0, 1)) gen_mtx[i] = -gen_mtx[i];
          end else begin
            gen_mtx[i] = $signed($urandom_range(0, 32'h8000)) - 32'sh4000;
          end
        end
        3: gen_mtx[i] = $urandom();
        5: gen_mtx[i] = $signed($urandom_range(0, 511)) - 32'sd256;
        6: begin
          r = $urandom_range(0, 4);
          gen_mtx[i] = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
                       (r == 2) ? 32'sd1 : (r == 3) ? -32'sd1 : 32'sd0;
        end
        7: gen_mtx[i] = (i % 5 == 0) ? $signed($urandom_range(1, 3)) : 32'sd0;
        default: gen_mtx[i] = $urandom();
      endcase
    end
    // Rank-deficient flavor: two equal rows force a zero determinant.
    if (flavor == 4) begin
      r = $urandom_range(1, 3);
      for (int c = 0; c < 4; c++) gen_mtx[r * 4 + c] = gen_mtx[c];
    end
  endtask

  // Stimulus: directed rows first, then random matrices with some broken sequences.
  initial begin
    stim_row_t row;
    int flavor;
    int partial;
    bit burst;
    bit paused;
    paused = 1'b0;
    load_idx = 0;
    // A partial matrix that the restart mark below throws away.
    for (int i = 0; i < 3; i++) begin
      directed[i].value = (i == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      directed[i].first = (i == 0);
      directed[i].kind = EXP_PREDICT;
    end
    // All-zero matrix after a restart mark: singular.
    for (int i = 0; i < 16; i++) begin
      directed[3 + i].value = '0;
      directed[3 + i].first = (i == 0);
      directed[3 + i].kind = (i == 15) ? EXP_SINGULAR : EXP_PREDICT;
    end
    // Identity without the mark: loading starts over on its own after a full matrix.
    for (int i = 0; i < 16; i++) begin
      directed[19 + i].value = (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
      directed[19 + i].first = 1'b0;
      directed[19 + i].kind = (i == 15) ? EXP_IDENTITY : EXP_PREDICT;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_beat(directed[i], 1'b0);

    row.kind = EXP_PREDICT;
    while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
      // Once midway, let the core drain completely before going on.
      if (!paused && beats_sent > DIRECTED_ROWS + RANDOM_BEATS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (pending_inv.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
      end
      burst = ($urandom_range(0, 3) == 0);
      partial = 0;
      // Now and then a broken matrix that a later restart mark discards.
      if ($urandom_range(0, 7) == 0) begin
        partial = $urandom_range(1, 12);
        for (int i = 0; i < partial; i++) begin
          row.value = $urandom();
          row.first = (i == 0) || ($urandom_range(0, 9) == 0);
          send_beat(row, burst);
        end
      end
      flavor = $urandom_range(0, 7);
      build_matrix(flavor);
      for (int i = 0; i < 16; i++) begin
        row.value = gen_mtx[i];
        // Element 0 goes unmarked at times, which is legal only on a matrix boundary.
        row.first = (i == 0) && (partial != 0 || load_idx != 0 || $urandom_range(0, 3) != 0);
        send_beat(row, burst);
      end
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off, and the comparison itself.
  initial begin
    inv_elem_t exp_e;
    int stall;
    bit burst;
    bit held;
    held = 1'b0;
    burst = 1'b0;
    @(posedge rst_n);
    forever begin
      if (results_seen % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 5);
      if (!held && results_seen == 40) begin
        held = 1'b1;
        stall = LONG_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (pending_inv.size() == 0) begin
        $display("%0t: result beat with nothing expected (value %h)", $time,
                 out_inverse_value);
        errors++;
      end else begin
        exp_e = pending_inv.pop_front();
        if (out_inverse_value !== exp_e.value) begin
          $display("%0t: inverse_value expected %h actual %h", $time, exp_e.value,
                   out_inverse_value);
          errors++;
        end
        if (out_singular !== exp_e.singular) begin
          $display("%0t: singular expected %b actual %b", $time, exp_e.singular,
                   out_singular);
          errors++;
        end
        if (out_saturated !== exp_e.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_e.saturated,
                   out_saturated);
          errors++;
        end
        if (out_last_element !== exp_e.last) begin
          $display("%0t: last_element expected %b actual %b", $time, exp_e.last,
                   out_last_element);
          errors++;
        end
      end
    end
  end

  // End of run: all beats sent, all results back, then a short drain for strays.
  initial begin
    wait (sender_done);
    while (pending_inv.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_inv.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
